>>> hdl/gmps_pkg.sv
package gmps_pkg;

  localparam int CfgW     = 10;
  localparam int LineIdxW = 9;
  localparam int MaxLines = 512;
  localparam int CellW    = 16;
  localparam int SumW     = 32;

  localparam logic [1:0] CFG_LINE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_LINE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_STEP_MODE   = 2'd2;

  localparam logic STEP_RIGHT_DOWN = 1'b0;
  localparam logic STEP_THREE_WAY  = 1'b1;

  typedef logic signed [CellW-1:0] cell_t;
  typedef logic signed [SumW-1:0]  sum_t;

  localparam sum_t SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam sum_t SumMax = {1'b0, {(SumW-1){1'b1}}};

  function automatic sum_t sat_add(sum_t a, cell_t b);
    logic signed [SumW:0] s;
    s = {a[SumW-1], a} + {{(SumW-CellW+1){b[CellW-1]}}, b};
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? SumMin : SumMax;
    end
    return s[SumW-1:0];
  endfunction

endpackage

>>> hdl/grid_max_path_sum_top.sv
// Grid maximum path sum.
// Matrix cells enter on the input channel (in_valid, in_stall, cell_value) one word
// per cell, line by line. After the last cell of a matrix one word carrying
// best_path_sum leaves on the output channel (out_valid, out_stall, best_path_sum).
// step_mode 0 sums a right/down path from the first to the last cell; step_mode 1
// lets each cell extend the best of its three neighbors in the previous line and
// reports the maximum over the last line.
// The user must write registers via cfg_we, cfg_index and cfg_data only while the
// block is idle, which it does not enforce. Every write restarts the current matrix.
// One cell is taken every cycle while in_stall is low. A cell's line store entries
// are read at the edge that accepts it; its sum is computed in the following cycle
// and written back as the cell leaves that stage, which also registers the result.
// The line store has one write and two read ports, which allows one cell per cycle.
// While out_valid is held by out_stall, cells that do not end a matrix still flow;
// in_stall rises only when a finished result waits behind a stalled result.
// Reset sets one line of one cell in step_mode 0 and clears all counters; the line
// store holds no meaningful data until the first line of a matrix has been written.
module grid_max_path_sum_top #(
  parameter int MAX_LINE = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [gmps_pkg::CfgW-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gmps_pkg::cell_t                      cell_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gmps_pkg::sum_t                       best_path_sum
);
  import gmps_pkg::*;

  localparam int PosW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

  logic [CfgW-1:0]     line_count;
  logic [CfgW-1:0]     line_length;
  logic                step_mode;

  logic [PosW-1:0]     pos;
  logic [LineIdxW-1:0] line_index;
  sum_t                left_sum;
  sum_t                held_previous_sum;
  sum_t                best_in_last_line;

  sum_t                line_store [MAX_LINE];
  sum_t                rd0;
  sum_t                rd1;

  logic                s1_valid;
  cell_t               s1_cell;
  logic [PosW-1:0]     s1_pos;
  logic                s1_first_line;
  logic                s1_last_line;
  logic                s1_last_pos;

  logic [PosW-1:0]     last_pos;
  logic [LineIdxW-1:0] last_line_idx;
  logic [PosW-1:0]     pos_inc;
  logic                at_last_pos;
  logic                at_last_line;
  logic                accept;
  logic                s1_result;
  logic                s1_done;
  sum_t                best;
  sum_t                sum;
  sum_t                result;

  always_comb begin
    if (line_length == '0) begin
      last_pos = '0;
    end else if (32'(line_length) > 32'(MAX_LINE)) begin
      last_pos = PosW'(MAX_LINE - 1);
    end else begin
      last_pos = PosW'(line_length - CfgW'(1));
    end
    if (line_count == '0) begin
      last_line_idx = '0;
    end else if (32'(line_count) > 32'(MaxLines)) begin
      last_line_idx = LineIdxW'(MaxLines - 1);
    end else begin
      last_line_idx = LineIdxW'(line_count - CfgW'(1));
    end
  end

  assign pos_inc      = pos + PosW'(1);
  assign at_last_pos  = (pos == last_pos);
  assign at_last_line = (line_index == last_line_idx);

  assign s1_result = s1_valid && s1_last_line && s1_last_pos;
  assign s1_done   = s1_valid && (!s1_result || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_done;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    best = rd0;
    if (step_mode == STEP_RIGHT_DOWN) begin
      if (s1_first_line) begin
        best = (s1_pos != '0) ? left_sum : '0;
      end else if (s1_pos != '0 && left_sum > best) begin
        best = left_sum;
      end
    end else begin
      if (s1_pos != '0 && held_previous_sum > best) begin
        best = held_previous_sum;
      end
      if (!s1_last_pos && rd1 > best) begin
        best = rd1;
      end
    end
    if (step_mode == STEP_THREE_WAY && s1_first_line) begin
      sum = {{(SumW-CellW){s1_cell[CellW-1]}}, s1_cell};
    end else begin
      sum = sat_add(best, s1_cell);
    end
    if (step_mode == STEP_RIGHT_DOWN) begin
      result = sum;
    end else begin
      result = (sum > best_in_last_line) ? sum : best_in_last_line;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      line_store[s1_pos] <= sum;
    end
    if (accept) begin
      rd0 <= (s1_done && s1_pos == pos) ? sum : line_store[pos];
      rd1 <= (s1_done && s1_pos == pos_inc) ? sum : line_store[pos_inc];
      s1_cell       <= cell_value;
      s1_pos        <= pos;
      s1_first_line <= (line_index == '0);
      s1_last_line  <= at_last_line;
      s1_last_pos   <= at_last_pos;
    end
    if (s1_done && s1_result) begin
      best_path_sum <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count        <= CfgW'(1);
      line_length       <= CfgW'(1);
      step_mode         <= STEP_RIGHT_DOWN;
      pos               <= '0;
      line_index        <= '0;
      left_sum          <= '0;
      held_previous_sum <= '0;
      best_in_last_line <= SumMin;
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LINE_COUNT:  line_count  <= cfg_data;
          CFG_LINE_LENGTH: line_length <= cfg_data;
          CFG_STEP_MODE:   step_mode   <= cfg_data[0];
          default: ;
        endcase
        pos               <= '0;
        line_index        <= '0;
        left_sum          <= '0;
        held_previous_sum <= '0;
        best_in_last_line <= SumMin;
      end else begin
        if (accept) begin
          if (at_last_pos) begin
            pos        <= '0;
            line_index <= at_last_line ? '0 : line_index + LineIdxW'(1);
          end else begin
            pos <= pos_inc;
          end
        end
        if (s1_done) begin
          if (s1_result) begin
            left_sum          <= '0;
            held_previous_sum <= '0;
            best_in_last_line <= SumMin;
          end else begin
            left_sum          <= sum;
            held_previous_sum <= rd0;
            if (step_mode == STEP_THREE_WAY && s1_last_line && sum > best_in_last_line) begin
              best_in_last_line <= sum;
            end
          end
        end
      end

      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end

      if (s1_done && s1_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/gmps_checker.sv
module gmps_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [31:0]        best_path_sum
);

  // A result word that is stalled stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(best_path_sum))
    else $error("stalled result word changed");

  // Input is held back only behind a stalled result word.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A fresh result follows a cell that was accepted and then left the s1 stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without a preceding cell");

  // Reset empties both stages.
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind grid_max_path_sum_top gmps_checker u_gmps_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .best_path_sum (best_path_sum)
);
